### rtl/fwsc_pkg.sv
// fwsc_pkg: shared types, codes and the byte-wide CRC-32 step for the
// flash write stream CRC checker. No dependencies.
`timescale 1ns / 1ps

package fwsc_pkg;

   // input op codes
   localparam logic [1:0] OP_ARM    = 2'd0;
   localparam logic [1:0] OP_DATA   = 2'd1;
   localparam logic [1:0] OP_STATUS = 2'd2;

   // result kinds
   localparam logic KIND_BYTE    = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   // verdict codes
   localparam logic [1:0] VERDICT_OK       = 2'd0;
   localparam logic [1:0] VERDICT_WR_FAIL  = 2'd1;
   localparam logic [1:0] VERDICT_CRC_FAIL = 2'd2;

   // csr register indexes
   localparam int          CSR_IDX_W        = 2;
   localparam logic [1:0]  CSR_BASE_ADDRESS = 2'd0;
   localparam logic [1:0]  CSR_XFER_LENGTH  = 2'd1;
   localparam logic [1:0]  CSR_EXPECTED_CRC = 2'd2;

   localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

   // result queue depth
   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = 2;
   localparam int RSP_CNT_W = 3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_RECV = 2'd1,
      PH_WAIT = 2'd2
   } phase_type;

   typedef struct packed {
      logic        kind;
      logic [31:0] flash_address;
      logic [7:0]  out_byte;
      logic        write_enable;
      logic        chunk_flush;
      logic [1:0]  verdict;
      logic [31:0] final_crc;
      logic        is_last;
   } rsp_word_type;

   // reflected CRC-32 update by one byte, with pre and post inversion
   function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = ~crc;
      c = c ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return ~c;
   endfunction

endpackage

### rtl/fwsc_req_if.sv
// fwsc_req_if: input word channel (valid/ready plus request fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface fwsc_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] op;
   logic [7:0] data_byte;
   logic       flash_failed;

   modport source (output valid, output op, output data_byte, output flash_failed,
                   input ready);
   modport sink   (input valid, input op, input data_byte, input flash_failed,
                   output ready);
endinterface

### rtl/fwsc_rsp_if.sv
// fwsc_rsp_if: result word channel (valid/ready plus result fields).
// Depends on nothing.
`timescale 1ns / 1ps

interface fwsc_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] flash_address;
   logic [7:0]  out_byte;
   logic        write_enable;
   logic        chunk_flush;
   logic [1:0]  verdict;
   logic [31:0] final_crc;
   logic        is_last;

   modport source (output valid, output kind, output flash_address, output out_byte,
                   output write_enable, output chunk_flush, output verdict,
                   output final_crc, output is_last, input ready);
   modport sink   (input valid, input kind, input flash_address, input out_byte,
                   input write_enable, input chunk_flush, input verdict,
                   input final_crc, input is_last, output ready);
endinterface

### rtl/fwsc_rsp_fifo.sv
// fwsc_rsp_fifo: small result queue taking up to two words per cycle.
// Depends on fwsc_pkg and fwsc_rsp_if.
`timescale 1ns / 1ps

module fwsc_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           push_n,
   input  fwsc_pkg::rsp_word_type push_word0,
   input  fwsc_pkg::rsp_word_type push_word1,
   output logic                 room2,
   fwsc_rsp_if.source           rsp_chan
);
   import fwsc_pkg::*;

   rsp_word_type          mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic [RSP_PTR_W-1:0]  wr_ptr_p1;
   logic                  pop;
   rsp_word_type          head;

   assign wr_ptr_p1 = wr_ptr_ff + RSP_PTR_W'(1);
   assign pop       = rsp_chan.valid && rsp_chan.ready;
   assign room2     = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));

   always_comb begin
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push_n);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + RSP_CNT_W'(push_n) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_n != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push_word0;
      end
      if (push_n == 2'd2) begin
         mem_ff[wr_ptr_p1] <= push_word1;
      end
   end

   assign head                   = mem_ff[rd_ptr_ff];
   assign rsp_chan.valid         = (count_ff != '0);
   assign rsp_chan.kind          = head.kind;
   assign rsp_chan.flash_address = head.flash_address;
   assign rsp_chan.out_byte      = head.out_byte;
   assign rsp_chan.write_enable  = head.write_enable;
   assign rsp_chan.chunk_flush   = head.chunk_flush;
   assign rsp_chan.verdict       = head.verdict;
   assign rsp_chan.final_crc     = head.final_crc;
   assign rsp_chan.is_last       = head.is_last;

endmodule

### rtl/flash_write_stream_crc_check_top.sv
// flash_write_stream_crc_check_top: CRC-checked byte stream toward flash.
// Depends on fwsc_pkg, fwsc_req_if, fwsc_rsp_if and fwsc_rsp_fifo.
// Path: an accepted word is held in the input register stage, then processed into
//   the result queue once it has room for two words; results appear on rsp_chan.
// Throughput: one request word per cycle while the queue has room for two words;
//   the byte CRC step is combinational and the four-entry queue drains one word per cycle.
// Reset (synchronous, active high): idle, counters and CRC cleared, queue empty.
`timescale 1ns / 1ps

module flash_write_stream_crc_check_top #(
   parameter int CHUNK_BYTES = 1024
) (
   input  logic                             clock,
   input  logic                             reset,
   fwsc_req_if.sink                         req_chan,
   fwsc_rsp_if.source                       rsp_chan,
   input  logic                             csr_wr_en,
   input  logic [fwsc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [31:0]                      csr_wdata
);
   import fwsc_pkg::*;

   localparam int FILL_W = $clog2(CHUNK_BYTES + 1);

   // config registers
   logic [31:0] base_ff, length_ff, exp_crc_ff;

   // input register stage
   logic        s1_valid_ff, s1_valid_in;
   logic [1:0]  s1_op_ff;
   logic [7:0]  s1_byte_ff;
   logic        s1_fail_ff;

   // transfer state
   phase_type          phase_ff, phase_in;
   logic [31:0]        count_ff, count_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [31:0]        crc_ff, crc_in;
   logic               failed_ff, failed_in;

   // processing
   logic               room2, advance, accept;
   logic [1:0]         push_n;
   rsp_word_type       word0, word1;
   logic [31:0]        crc_next, count_p1;
   logic [FILL_W-1:0]  fill_p1;
   logic               last, flush, fail_now;

   // Config writes must come only while idle; the block does not enforce this (no interlock).
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff    <= '0;
         length_ff  <= 32'd1;
         exp_crc_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_BASE_ADDRESS: base_ff    <= csr_wdata;
            CSR_XFER_LENGTH:  length_ff  <= csr_wdata;
            CSR_EXPECTED_CRC: exp_crc_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The input stage moves on whenever the queue can take a worst-case pair.
   assign advance        = s1_valid_ff && room2;
   assign req_chan.ready = !s1_valid_ff || room2;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_op_ff   <= req_chan.op;
         s1_byte_ff <= req_chan.data_byte;
         s1_fail_ff <= req_chan.flash_failed;
      end
   end

   // Byte-path arithmetic; count stays below length so count+1 fits in 32 bits.
   assign crc_next = crc_byte(crc_ff, s1_byte_ff);
   assign count_p1 = count_ff + 32'd1;
   assign fill_p1  = fill_ff + FILL_W'(1);
   assign last     = (count_p1 == length_ff);
   assign flush    = last || (fill_p1 >= FILL_W'(CHUNK_BYTES));
   assign fail_now = failed_ff || s1_fail_ff;

   // Next state and result words.
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      fill_in   = fill_ff;
      crc_in    = crc_ff;
      failed_in = failed_ff;
      push_n    = 2'd0;
      word0     = '0;
      word1     = '0;

      if (advance) begin
         case (s1_op_ff)
            OP_ARM: begin
               count_in  = '0;
               fill_in   = '0;
               crc_in    = '0;
               failed_in = 1'b0;
               phase_in  = (length_ff != '0) ? PH_RECV : PH_IDLE;
            end
            OP_DATA: begin
               // bytes past the length or outside a transfer are dropped
               if (phase_ff == PH_RECV && count_ff < length_ff) begin
                  crc_in               = crc_next;
                  count_in             = count_p1;
                  fill_in              = flush ? '0 : fill_p1;
                  push_n               = 2'd1;
                  word0.kind           = KIND_BYTE;
                  word0.flash_address  = base_ff + count_ff;
                  word0.out_byte       = s1_byte_ff;
                  word0.write_enable   = !failed_ff;
                  word0.chunk_flush    = flush;
                  word0.is_last        = 1'b1;
                  if (last) begin
                     if (failed_ff) begin
                        // already failed: verdict follows the byte at once
                        word0.is_last   = 1'b0;
                        push_n          = 2'd2;
                        word1.kind      = KIND_VERDICT;
                        word1.verdict   = VERDICT_WR_FAIL;
                        word1.final_crc = crc_next;
                        word1.is_last   = 1'b1;
                        phase_in        = PH_IDLE;
                     end else begin
                        phase_in = PH_WAIT;
                     end
                  end
               end
            end
            OP_STATUS: begin
               if (phase_ff == PH_RECV) begin
                  failed_in = fail_now;
               end else if (phase_ff == PH_WAIT) begin
                  // last chunk's status closes the transfer
                  failed_in       = fail_now;
                  push_n          = 2'd1;
                  word0.kind      = KIND_VERDICT;
                  word0.final_crc = crc_ff;
                  word0.is_last   = 1'b1;
                  if (fail_now) begin
                     word0.verdict = VERDICT_WR_FAIL;
                  end else if (crc_ff != exp_crc_ff) begin
                     word0.verdict = VERDICT_CRC_FAIL;
                  end else begin
                     word0.verdict = VERDICT_OK;
                  end
                  phase_in = PH_IDLE;
               end
            end
            default: ;   // op 3 means nothing
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         count_ff  <= '0;
         fill_ff   <= '0;
         crc_ff    <= '0;
         failed_ff <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         fill_ff   <= fill_in;
         crc_ff    <= crc_in;
         failed_ff <= failed_in;
      end
   end

   // Result queue: absorbs the byte-plus-verdict pair and output stalls.
   fwsc_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_n     (push_n),
      .push_word0 (word0),
      .push_word1 (word1),
      .room2      (room2),
      .rsp_chan   (rsp_chan)
   );

endmodule
